@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define TFD_ASSERT_CR(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Short form for modules that use the house clock and reset names.
`define TFD_ASSERT(lbl, prop, msg) \
    `TFD_ASSERT_CR(lbl, i_clk, i_rst_n, prop, msg)

`endif

@@ rtl/tfd_pkg.sv @@
`timescale 1ns / 1ps

package tfd_pkg;

    localparam logic [7:0] ESC_BYTE    = 8'h7D;
    localparam logic [7:0] ESC_ADD     = 8'h20;
    localparam logic [7:0] START_RESET = 8'h10;

    // Unstuffed byte handed from the unstuff stage to the framer.
    typedef struct packed {
        logic       vld;
        logic [7:0] data;
    } t_ubyte;

    // One completed frame.
    typedef struct packed {
        logic        vld;
        logic [15:0] id;
        logic [31:0] value;
        logic        ok;
    } t_result;

    // End-around-carry byte add (ones' complement style).
    function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[7:0] + {7'd0, s[8]};
    endfunction

endpackage

@@ rtl/tfd_unstuff.sv @@
`timescale 1ns / 1ps

module tfd_unstuff (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_byte,
    output tfd_pkg::t_ubyte o_ub
);
    import tfd_pkg::*;

    logic r_esc;
    logic n_esc;
    logic is_esc;

    assign is_esc = !r_esc && (i_byte == ESC_BYTE);
    // escape byte itself is swallowed; the following byte gets the offset
    assign n_esc     = is_esc;
    assign o_ub.vld  = i_take && !is_esc;
    assign o_ub.data = r_esc ? (i_byte + ESC_ADD) : i_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
        end else if (i_take) begin
            r_esc <= n_esc;
        end
    end

endmodule

@@ rtl/tfd_frame.sv @@
`timescale 1ns / 1ps

module tfd_frame (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tfd_pkg::t_ubyte i_ub,
    input  logic [7:0]      i_start,
    output tfd_pkg::t_result o_res
);
    import tfd_pkg::*;

    localparam logic [2:0] POS_HUNT = 3'd0;
    localparam logic [2:0] POS_LAST = 3'd6;
    localparam logic [2:0] POS_CSUM = 3'd7;

    logic [2:0] r_pos;
    logic [2:0] n_pos;
    logic [7:0] r_bytes [0:5];
    logic [7:0] r_acc;      // EAC sum of payload so far, seed added at the end
    logic [7:0] n_acc;
    logic [2:0] wr_idx;
    logic [7:0] sum;

    assign wr_idx = r_pos - 3'd1;
    // EAC sum is order independent, so the seed can be folded in last
    assign sum    = eac_add(i_start, r_acc);

    always_comb begin
        n_pos = r_pos;
        n_acc = r_acc;
        if (i_ub.vld) begin
            case (r_pos)
                POS_HUNT: begin
                    if (i_ub.data == i_start) begin
                        n_pos = 3'd1;
                        n_acc = 8'd0;
                    end
                end
                POS_CSUM: begin
                    n_pos = POS_HUNT;
                end
                default: begin
                    n_pos = r_pos + 3'd1;
                    n_acc = eac_add(r_acc, i_ub.data);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_ub.vld && (r_pos != POS_HUNT) && (r_pos <= POS_LAST)) begin
            r_bytes[wr_idx] <= i_ub.data;
        end
    end

    assign o_res.vld   = i_ub.vld && (r_pos == POS_CSUM);
    assign o_res.id    = {r_bytes[1], r_bytes[0]};
    assign o_res.value = {r_bytes[5], r_bytes[4], r_bytes[3], r_bytes[2]};
    assign o_res.ok    = (~sum == i_ub.data);

endmodule

@@ rtl/telemetry_frame_deframer_unit.sv @@
`timescale 1ns / 1ps
// Telemetry frame deframer.
// Input channel: one raw serial byte per request (i_valid / o_stall, i_rx_byte).
//   A request is taken on a clock edge with i_valid high and o_stall low.
// Output channel: one frame per request (o_valid / i_stall) with the sensor id,
//   the 32-bit little-endian value and a checksum pass flag. Frames failing the
//   checksum are still delivered with o_checksum_ok low.
// Config channel: i_cfg_valid / o_cfg_ready with i_cfg_data = start byte
//   (also the checksum seed). o_cfg_ready is always high; write while idle.
// Output timing: the checksum byte passes the input register, then the result register,
//   before o_valid rises; the receiver can take it next edge.
// Throughput: one byte per cycle sustained unless the receiver stalls; per-byte work
//   is one 8-bit end-around-carry add, with the seed folded in on the checksum byte.
// Reset (i_rst_n low, synchronous): start byte returns to 0x10, escape state
//   and frame position clear, both pipeline registers empty.
// Receiver stall: the result register holds its frame and every byte waits
//   behind it; the input register takes at most one more byte, then o_stall
//   stays high until the held frame is taken.

module telemetry_frame_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_sensor_id,
    output logic [31:0] o_sensor_value,
    output logic        o_checksum_ok,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    import tfd_pkg::*;

    logic [7:0]  r_start_byte;
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_out_vld;
    t_result     r_out;
    logic        advance;
    logic        take;
    t_ubyte      ub;
    t_result     res;

    // result stage free or being emptied this cycle
    assign advance = !(r_out_vld && i_stall);
    assign take    = r_in_vld && advance;
    assign o_stall = r_in_vld && !advance;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_start_byte <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    tfd_unstuff u_unstuff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (r_in_byte),
        .o_ub    (ub)
    );

    tfd_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ub    (ub),
        .i_start (r_start_byte),
        .o_res   (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.vld) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_sensor_id    = r_out.id;
    assign o_sensor_value = r_out.value;
    assign o_checksum_ok  = r_out.ok;

endmodule

@@ rtl/tfd_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_sensor_id,
    input logic [31:0] o_sensor_value,
    input logic        o_checksum_ok
);

    logic [48:0] frame_bits;
    logic        in_acc;

    assign frame_bits = {o_sensor_id, o_sensor_value, o_checksum_ok};
    assign in_acc     = i_valid && !o_stall;

    // held frame stays put while the receiver stalls
    `TFD_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(frame_bits), "frame changed")

    // input back-pressure only comes from a blocked result stage
    `TFD_ASSERT(a_stall_cause, o_stall |-> o_valid && i_stall, "stall without blocked output")

    // a fresh frame needs a byte taken through the input register before the result register
    `TFD_ASSERT(a_out_source, $rose(o_valid) |-> $past(in_acc, 2), "result without input")

endmodule

bind telemetry_frame_deframer_unit tfd_checker u_tfd_checker (.*);
